>>> rtl/rdt_pkg.sv
// ============================================================================
// rdt_pkg - shared types and constants for the running drawdown tracker
// Work descriptors passed from the front end to the back end, result
// layout and fixed arithmetic constants.
// ============================================================================
package rdt_pkg;

    localparam int TimeWidth   = 48;
    localparam int EquityWidth = 48;
    localparam int BpWidth     = 31;
    localparam int NetWidth    = 49;
    localparam int ProdWidth   = 62;  // (peak - equity) * 10000 stays below 2^62

    localparam logic [13:0]        BP_SCALE = 14'd10000;
    localparam logic [BpWidth-1:0] BP_MAX   = {BpWidth{1'b1}};

    // Commands of the sample channel
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // One classified transaction waiting for the back end
    typedef struct packed {
        logic                          is_clear;
        logic                          do_div;      // peak positive after update
        logic [TimeWidth-1:0]          sample_time;
        logic signed [EquityWidth-1:0] peak;
        logic [EquityWidth-1:0]        diff;        // peak - equity, never negative
        logic [TimeWidth-1:0]          below;
        logic signed [NetWidth-1:0]    net;
    } job_t;

endpackage

>>> rtl/rdt_sample_if.sv
// ============================================================================
// rdt_sample_if - equity sample channel
// Valid/ready channel carrying a command, a timestamp and an equity value.
// ============================================================================
interface rdt_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic [rdt_pkg::TimeWidth-1:0]          sample_time;
    logic signed [rdt_pkg::EquityWidth-1:0] equity_value;

    modport source (output valid, output command, output sample_time,
                    output equity_value, input ready);
    modport sink   (input valid, input command, input sample_time,
                    input equity_value, output ready);
endinterface

>>> rtl/rdt_result_if.sv
// ============================================================================
// rdt_result_if - drawdown result channel
// Valid/ready channel carrying one drawdown result per transaction.
// ============================================================================
interface rdt_result_if;
    logic                                   valid;
    logic                                   ready;
    logic [rdt_pkg::BpWidth-1:0]            current_drawdown_bp;
    logic [rdt_pkg::BpWidth-1:0]            max_drawdown_bp;
    logic [rdt_pkg::TimeWidth-1:0]          max_drawdown_time;
    logic signed [rdt_pkg::EquityWidth-1:0] peak_value;
    logic [rdt_pkg::TimeWidth-1:0]          below_peak_time;
    logic signed [rdt_pkg::NetWidth-1:0]    net_change;

    modport source (output valid, output current_drawdown_bp, output max_drawdown_bp,
                    output max_drawdown_time, output peak_value,
                    output below_peak_time, output net_change, input ready);
    modport sink   (input valid, input current_drawdown_bp, input max_drawdown_bp,
                    input max_drawdown_time, input peak_value,
                    input below_peak_time, input net_change, output ready);
endinterface

>>> rtl/running_drawdown_tracker.sv
// ============================================================================
// running_drawdown_tracker - running peak and maximum drawdown of equity
// Top level: intake front end, work queue and divider back end.
// ============================================================================
// Each sample transaction yields one result transaction, in order. A record
// passes through the back end in steps: the work item is picked up, multiplied
// by 10000, divided by the peak in the one-bit-per-cycle restoring divider,
// and loaded into the result register. Clears and samples whose peak is not
// positive skip the multiply and the divider. The front end keeps accepting
// samples while the queue (QUEUE_DEPTH entries) has room, and the result
// register holds a finished result while the next one is computed.
module running_drawdown_tracker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    rdt_sample_if.sink   samples,
    rdt_result_if.source results
);

    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    rdt_pkg::job_t push_job;
    rdt_pkg::job_t head_job;

    rdt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    rdt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    rdt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_job    (head_job),
        .pop         (pop),
        .results     (results)
    );

endmodule

>>> rtl/rdt_front.sv
// ============================================================================
// rdt_front - sample intake and classification
// Accepts samples, tracks peak, peak time and first equity, and emits a
// work descriptor per transaction into the queue.
// ============================================================================
module rdt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    rdt_sample_if.sink           samples,
    input  logic                 queue_full,
    output logic                 push,
    output rdt_pkg::job_t        job
);

    logic signed [rdt_pkg::EquityWidth-1:0] peak_reg, peak_next;
    logic [rdt_pkg::TimeWidth-1:0]          peak_time_reg, peak_time_next;
    logic signed [rdt_pkg::EquityWidth-1:0] first_reg, first_next;
    logic                                   have_reg, have_next;

    logic                                   new_peak;
    logic signed [rdt_pkg::EquityWidth-1:0] eq;
    logic signed [rdt_pkg::EquityWidth-1:0] first_eff;
    logic                                   is_clear;

    assign samples.ready = !queue_full;
    assign push          = samples.valid && !queue_full;
    assign eq            = samples.equity_value;
    assign is_clear      = (samples.command == rdt_pkg::CMD_CLEAR);
    assign new_peak      = (eq > peak_reg);
    assign first_eff     = have_reg ? first_reg : eq;

    // Classify: all compares and subtracts work from the stored state in parallel
    always_comb
    begin
        job.is_clear    = is_clear;
        job.do_div      = !is_clear && (new_peak ? (eq > 0) : (peak_reg > 0));
        job.sample_time = samples.sample_time;
        job.peak        = new_peak ? eq : peak_reg;
        job.diff        = new_peak ? '0 : (peak_reg - eq);
        job.below       = (eq < peak_reg) ? (samples.sample_time - peak_time_reg) : '0;
        job.net         = {eq[rdt_pkg::EquityWidth-1], eq}
                        - {first_eff[rdt_pkg::EquityWidth-1], first_eff};
        if (is_clear)
        begin
            job.peak  = '0;
            job.diff  = '0;
            job.below = '0;
            job.net   = '0;
        end
    end

    // Tracking state update
    always_comb
    begin
        peak_next      = peak_reg;
        peak_time_next = peak_time_reg;
        first_next     = first_reg;
        have_next      = have_reg;
        if (push)
        begin
            if (is_clear)
            begin
                peak_next      = '0;
                peak_time_next = '0;
                first_next     = '0;
                have_next      = 1'b0;
            end
            else
            begin
                first_next = first_eff;
                have_next  = 1'b1;
                if (new_peak)
                begin
                    peak_next      = eq;
                    peak_time_next = samples.sample_time;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            peak_time_reg <= '0;
            first_reg     <= '0;
            have_reg      <= 1'b0;
        end
        else
        begin
            peak_reg      <= peak_next;
            peak_time_reg <= peak_time_next;
            first_reg     <= first_next;
            have_reg      <= have_next;
        end
    end

endmodule

>>> rtl/rdt_queue.sv
// ============================================================================
// rdt_queue - work descriptor FIFO
// Small register FIFO decoupling intake from the divider back end.
// ============================================================================
module rdt_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rdt_pkg::job_t push_job,
    input  logic          pop,
    output rdt_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);

    rdt_pkg::job_t         slots_reg [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0]   count_reg, count_next;

    assign full     = (count_reg == CntWidth'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slots_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/rdt_back.sv
// ============================================================================
// rdt_back - drawdown computation and result stage
// Scales the drop by 10000, divides by the peak one bit per cycle, keeps
// the worst drawdown and drives the result register.
// ============================================================================
module rdt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          queue_empty,
    input  rdt_pkg::job_t head_job,
    output logic          pop,
    rdt_result_if.source  results
);

    localparam int DivSteps = rdt_pkg::ProdWidth;
    localparam int CntWidth = $clog2(DivSteps);
    localparam int PW       = rdt_pkg::ProdWidth;
    localparam int EW       = rdt_pkg::EquityWidth;
    localparam int BW       = rdt_pkg::BpWidth;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    rdt_pkg::job_t                  job_reg, job_next;
    logic [PW-1:0]                  quo_reg, quo_next;
    logic [EW-1:0]                  rem_reg, rem_next;
    logic [CntWidth-1:0]            cnt_reg, cnt_next;
    logic [BW-1:0]                  worst_reg, worst_next;
    logic [rdt_pkg::TimeWidth-1:0]  worst_time_reg, worst_time_next;
    logic                           out_valid_reg, out_valid_next;

    logic [BW-1:0]                  cur_reg;
    logic [BW-1:0]                  max_reg;
    logic [rdt_pkg::TimeWidth-1:0]  max_time_reg;
    logic signed [EW-1:0]           peak_out_reg;
    logic [rdt_pkg::TimeWidth-1:0]  below_reg;
    logic signed [rdt_pkg::NetWidth-1:0] net_reg;

    logic [PW-1:0]                  product;
    logic [EW-1:0]                  partial;
    logic [EW:0]                    trial;
    logic                           load;
    logic [BW-1:0]                  cur;

    // Scaled drop, registered before the divider starts
    assign product = PW'(job_reg.diff) * PW'(rdt_pkg::BP_SCALE);

    // Restoring divide step; remainder stays below the 47-bit divisor
    assign partial = {rem_reg[EW-2:0], quo_reg[PW-1]};
    assign trial   = {1'b0, partial} - {1'b0, job_reg.peak};

    // Saturated quotient of the current drawdown
    always_comb
    begin
        if (!job_reg.do_div)
        begin
            cur = '0;
        end
        else if (|quo_reg[PW-1:BW])
        begin
            cur = rdt_pkg::BP_MAX;
        end
        else
        begin
            cur = quo_reg[BW-1:0];
        end
    end

    assign load = (state_reg == S_DONE) && (!out_valid_reg || results.ready);
    assign pop  = (state_reg == S_IDLE) && !queue_empty;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        worst_next      = worst_reg;
        worst_time_next = worst_time_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    job_next   = head_job;
                    state_next = head_job.do_div ? S_MUL : S_DONE;
                end
            end
            S_MUL:
            begin
                quo_next   = product;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!trial[EW])
                begin
                    rem_next = trial[EW-1:0];
                end
                else
                begin
                    rem_next = partial;
                end
                quo_next = {quo_reg[PW-2:0], !trial[EW]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntWidth'(DivSteps - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                    if (job_reg.is_clear)
                    begin
                        worst_next      = '0;
                        worst_time_next = '0;
                    end
                    else if (cur > worst_reg)
                    begin
                        worst_next      = cur;
                        worst_time_next = job_reg.sample_time;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            worst_reg      <= '0;
            worst_time_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            worst_reg      <= worst_next;
            worst_time_reg <= worst_time_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load)
        begin
            cur_reg      <= job_reg.is_clear ? '0 : cur;
            max_reg      <= worst_next;
            max_time_reg <= worst_time_next;
            peak_out_reg <= job_reg.peak;
            below_reg    <= job_reg.below;
            net_reg      <= job_reg.net;
        end
    end

    assign results.valid               = out_valid_reg;
    assign results.current_drawdown_bp = cur_reg;
    assign results.max_drawdown_bp     = max_reg;
    assign results.max_drawdown_time   = max_time_reg;
    assign results.peak_value          = peak_out_reg;
    assign results.below_peak_time     = below_reg;
    assign results.net_change          = net_reg;

`ifndef SYNTHESIS
    // Divider never runs past its last step
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= CntWidth'(DivSteps - 1)))
        else $error("divider step count overrun");

    // Queue is only drained while the sequencer is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_MUL || state_reg == S_DONE))
        else $error("pop outside idle");

    // A delivered clear leaves the worst drawdown at zero
    a_clear_worst: assert property (@(posedge clk) disable iff (!rst_n)
        (load && job_reg.is_clear) |=> (worst_reg == '0 && worst_time_reg == '0))
        else $error("clear did not reset worst drawdown");

    // Worst drawdown only drops on a clear
    a_worst_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (!(load && job_reg.is_clear)) |=> (worst_reg >= $past(worst_reg)))
        else $error("worst drawdown decreased");
`endif

endmodule
